// ===== rtl/i2c_master_transfer_sequencer_defines.svh =====
// assertion macros used by the checker file
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define I2CMS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2cms assertion failed");

// next-cycle implication, checked outside reset
`define I2CMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2cms assertion failed");

`endif

// ===== rtl/i2cms_pkg.sv =====
// shared types and codes of the transfer sequencer
`default_nettype none

package i2cms_pkg;

  localparam int PhaseW = 4;
  localparam int CmdW   = 3;
  localparam int StatW  = 2;

  // sequencer phases
  localparam logic [PhaseW-1:0] PH_IDLE   = 4'd0;
  localparam logic [PhaseW-1:0] PH_W_ADDR = 4'd1;
  localparam logic [PhaseW-1:0] PH_W_DATA = 4'd2;
  localparam logic [PhaseW-1:0] PH_W_STOP = 4'd3;
  localparam logic [PhaseW-1:0] PH_W_END  = 4'd4;
  localparam logic [PhaseW-1:0] PH_R_ADDR = 4'd5;
  localparam logic [PhaseW-1:0] PH_R_DATA = 4'd6;
  localparam logic [PhaseW-1:0] PH_R_STOP = 4'd7;
  localparam logic [PhaseW-1:0] PH_R_END  = 4'd8;

  // engine commands
  localparam logic [CmdW-1:0] CMD_NONE  = 3'd0;
  localparam logic [CmdW-1:0] CMD_START = 3'd1;
  localparam logic [CmdW-1:0] CMD_SEND  = 3'd2;
  localparam logic [CmdW-1:0] CMD_RACK  = 3'd3;
  localparam logic [CmdW-1:0] CMD_RNACK = 3'd4;
  localparam logic [CmdW-1:0] CMD_STOP  = 3'd5;

  // transfer status
  localparam logic [StatW-1:0] ST_PENDING = 2'd0;
  localparam logic [StatW-1:0] ST_OK      = 2'd1;
  localparam logic [StatW-1:0] ST_NOT_OK  = 2'd2;

  typedef struct packed {
    logic       mode;
    logic [6:0] target_address;
    logic [7:0] byte_count;
    logic [7:0] tx_byte;
    logic       op_done;
    logic       stop_busy;
    logic [7:0] engine_rx_byte;
  } poll_t;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [7:0]       bus_byte;
    logic [StatW-1:0] status;
    logic             rx_valid;
    logic [7:0]       rx_data;
    logic [7:0]       rx_index;
    logic [7:0]       next_index;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/i2cms_if.sv =====
// valid/ready channel interfaces for polls and results
`default_nettype none

interface i2cms_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [6:0] target_address;
  logic [7:0] byte_count;
  logic [7:0] tx_byte;
  logic       op_done;
  logic       stop_busy;
  logic [7:0] engine_rx_byte;

  modport source (output valid, mode, target_address, byte_count, tx_byte, op_done,
                  stop_busy, engine_rx_byte, input ready);
  modport sink (input valid, mode, target_address, byte_count, tx_byte, op_done,
                stop_busy, engine_rx_byte, output ready);
endinterface

interface i2cms_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] bus_byte;
  logic [1:0] status;
  logic       rx_valid;
  logic [7:0] rx_data;
  logic [7:0] rx_index;
  logic [7:0] next_index;

  modport source (output valid, command, bus_byte, status, rx_valid, rx_data, rx_index,
                  next_index, input ready);
  modport sink (input valid, command, bus_byte, status, rx_valid, rx_data, rx_index,
                next_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/i2cms_step.sv =====
// next-phase and result logic for one poll
`default_nettype none

module i2cms_step import i2cms_pkg::*; (
  input  wire poll_t             poll,
  input  wire logic [PhaseW-1:0] phase,
  input  wire logic [7:0]        byte_index,
  output      logic [PhaseW-1:0] phase_nxt,
  output      logic [7:0]        byte_index_nxt,
  output      result_t           res
);

  logic [PhaseW-1:0] cur;
  logic              cur_read;
  logic [7:0]        idx_inc;
  logic [8:0]        idx_inc_w;
  logic [7:0]        idx_nxt;

  always_comb begin
    // out-of-range codes fall back to idle
    cur       = (phase > PH_R_END) ? PH_IDLE : phase;
    cur_read  = (cur >= PH_R_ADDR) && (cur <= PH_R_END);
    idx_inc   = byte_index + 8'd1;
    idx_inc_w = {1'b0, byte_index} + 9'd1;

    phase_nxt    = cur;
    idx_nxt      = byte_index;
    res          = '0;
    res.command  = CMD_NONE;
    res.status   = ST_PENDING;

    if ((cur != PH_IDLE) && (cur_read != poll.mode)) begin
      res.status = ST_NOT_OK;
    end else begin
      case (cur)
        PH_IDLE: begin
          res.command = CMD_START;
          idx_nxt     = 8'd0;
          phase_nxt   = poll.mode ? PH_R_ADDR : PH_W_ADDR;
        end
        PH_W_ADDR, PH_R_ADDR: begin
          if (poll.op_done) begin
            res.command  = CMD_SEND;
            res.bus_byte = {poll.target_address, poll.mode};
            phase_nxt    = poll.mode ? PH_R_DATA : PH_W_DATA;
          end
        end
        PH_W_DATA: begin
          if (poll.op_done) begin
            res.command  = CMD_SEND;
            res.bus_byte = poll.tx_byte;
            idx_nxt      = idx_inc;
            if (idx_inc >= poll.byte_count) phase_nxt = PH_W_STOP;
          end
        end
        PH_R_DATA: begin
          if (poll.op_done) begin
            if (byte_index != 8'd0) begin
              res.rx_valid = 1'b1;
              res.rx_data  = poll.engine_rx_byte;
              res.rx_index = byte_index - 8'd1;
            end
            if (byte_index < poll.byte_count) begin
              res.command = (idx_inc_w < {1'b0, poll.byte_count}) ? CMD_RACK : CMD_RNACK;
              idx_nxt     = idx_inc;
            end else begin
              phase_nxt = PH_R_STOP;
            end
          end
        end
        PH_W_STOP, PH_R_STOP: begin
          if (poll.op_done) begin
            res.command = CMD_STOP;
            phase_nxt   = poll.mode ? PH_R_END : PH_W_END;
          end
        end
        default: begin
          res.status = ST_OK;
          if (!poll.stop_busy) phase_nxt = PH_IDLE;
        end
      endcase
    end

    byte_index_nxt = idx_nxt;
    res.next_index = idx_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/i2c_master_transfer_sequencer.sv =====
// top level of the polled two-wire bus master transfer sequencer
`default_nettype none

// Polled master sequencer for a byte-level two-wire bus engine. Every poll
// transaction on in_ch yields exactly one result transaction on out_ch, in
// order. A poll is captured in an input register, evaluated against the
// sequencer phase and byte index in one short logic pass, and written to a
// result register together with the state update. A poll passes through the
// input register and then the result register before its result is offered
// on out_ch. With out_ch ready, one poll per cycle is sustained, and
// in_ch.ready stays high while a finished result waits, as long as the result
// register can move on in the same cycle. Only a stalled out_ch backs up into
// the input register. The transfer runs start, address with direction bit,
// data bytes (reads acknowledge all but the last byte), stop, then reports ok
// until the engine drops stop_busy. A poll whose mode disagrees with the
// transfer in progress returns not_ok and leaves the state untouched.
module i2c_master_transfer_sequencer import i2cms_pkg::*; (
  input wire logic   clk,
  input wire logic   rst_n,
  i2cms_in_if.sink   in_ch,
  i2cms_out_if.source out_ch
);

  // input stage
  logic    in_full_r;
  logic    in_full_nxt;
  poll_t   poll_r;

  // result stage
  logic    out_full_r;
  logic    out_full_nxt;
  result_t res_r;
  result_t res_nxt;

  // sequencer state
  logic [PhaseW-1:0] phase_r;
  logic [PhaseW-1:0] phase_nxt;
  logic [7:0]        idx_r;
  logic [7:0]        idx_nxt;

  logic    advance;
  logic    in_take;
  poll_t   poll_in;

  // the registered poll moves into the result register when that is free
  // or its transaction completes this cycle
  assign advance      = in_full_r && (!out_full_r || out_ch.ready);
  assign in_ch.ready  = !in_full_r || advance;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign in_full_nxt  = in_take || (in_full_r && !advance);
  assign out_full_nxt = advance || (out_full_r && !out_ch.ready);

  always_comb begin
    poll_in.mode           = in_ch.mode;
    poll_in.target_address = in_ch.target_address;
    poll_in.byte_count     = in_ch.byte_count;
    poll_in.tx_byte        = in_ch.tx_byte;
    poll_in.op_done        = in_ch.op_done;
    poll_in.stop_busy      = in_ch.stop_busy;
    poll_in.engine_rx_byte = in_ch.engine_rx_byte;
  end

  // phase decision for the registered poll
  i2cms_step u_step (
    .poll           (poll_r),
    .phase          (phase_r),
    .byte_index     (idx_r),
    .phase_nxt      (phase_nxt),
    .byte_index_nxt (idx_nxt),
    .res            (res_nxt)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r  <= 1'b0;
      out_full_r <= 1'b0;
      phase_r    <= PH_IDLE;
      idx_r      <= 8'd0;
    end else begin
      in_full_r  <= in_full_nxt;
      out_full_r <= out_full_nxt;
      // state only moves when a poll is actually evaluated
      if (advance) begin
        phase_r <= phase_nxt;
        idx_r   <= idx_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) poll_r <= poll_in;
    if (advance) res_r <= res_nxt;
  end

  assign out_ch.valid      = out_full_r;
  assign out_ch.command    = res_r.command;
  assign out_ch.bus_byte   = res_r.bus_byte;
  assign out_ch.status     = res_r.status;
  assign out_ch.rx_valid   = res_r.rx_valid;
  assign out_ch.rx_data    = res_r.rx_data;
  assign out_ch.rx_index   = res_r.rx_index;
  assign out_ch.next_index = res_r.next_index;

endmodule

`default_nettype wire

// ===== rtl/i2cms_checker.sv =====
// port-level checker for the transfer sequencer, bound to the top level
`default_nettype none
`include "i2c_master_transfer_sequencer_defines.svh"

module i2cms_checker import i2cms_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [CmdW-1:0]  out_command,
  input wire logic [7:0]       out_bus_byte,
  input wire logic [StatW-1:0] out_status,
  input wire logic             out_rx_valid
);

  logic out_stall;
  assign out_stall = out_valid && !out_ready;

  `I2CMS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid)
  `I2CMS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_stall, $stable(out_command) && $stable(out_status))
  `I2CMS_ASSERT_IMPLY(a_status_idle_cmd, clk, rst_n, out_valid && (out_status != ST_PENDING), (out_command == CMD_NONE) && !out_rx_valid)
  `I2CMS_ASSERT_IMPLY(a_byte_only_send, clk, rst_n, out_valid && (out_bus_byte != 8'd0), out_command == CMD_SEND)

endmodule

bind i2c_master_transfer_sequencer i2cms_checker u_i2cms_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_command  (out_ch.command),
  .out_bus_byte (out_ch.bus_byte),
  .out_status   (out_ch.status),
  .out_rx_valid (out_ch.rx_valid)
);

`default_nettype wire
